// ===== rtl/core/neighbour_mean_smoothing_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the neighbour mean smoothing block
// Concurrent checks that compile out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_MEAN_SMOOTHING_DEFINES_SVH
`define NEIGHBOUR_MEAN_SMOOTHING_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define NMS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nms assertion failed");
// Next-cycle implication
`define NMS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nms assertion failed");
`else
`define NMS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define NMS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/nms_pkg.sv =====
// ----------------------------------------------------------------------------
// nms_pkg
// Widths, constants and the window tap table of the neighbour mean smoother.
// ----------------------------------------------------------------------------
package nms_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 64;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    // Address is row * MAX_COLUMNS + column; MAX_COLUMNS is a power of two,
    // so the address is the concatenation of row and column.
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;

    localparam int DATA_W = 16;
    localparam int DIM_W  = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    localparam int CNT_W   = 4;                 // neighbour count 0..8
    localparam int SUM_W   = 19;                // eight signed 16-bit values
    localparam int FRAC_W  = 8;
    localparam int DVD_W   = SUM_W + FRAC_W;    // dividend magnitude
    localparam int QUO_W   = 24;                // mean_value width
    localparam int REM_W   = 3;                 // remainder below divisor <= 8
    localparam int STEP_W  = 5;                 // divider step counter

    localparam int TAP_W    = 4;
    localparam int TAP_LAST = 9;                // one past the last window tap
    localparam int TAP_MID  = 4;                // centre of the window

    // Offset codes for one axis of the window
    localparam logic [1:0] OFS_DEC  = 2'd0;
    localparam logic [1:0] OFS_SAME = 2'd1;
    localparam logic [1:0] OFS_INC  = 2'd2;

    typedef struct packed {
        logic [1:0] dr;
        logic [1:0] dc;
    } tap_t;

    // Window tap k, row major over the 3x3 window
    function automatic tap_t tap_offset(input logic [TAP_W-1:0] k);
        tap_t t;
        case (k)
            4'd0:    t = '{dr: OFS_DEC,  dc: OFS_DEC};
            4'd1:    t = '{dr: OFS_DEC,  dc: OFS_SAME};
            4'd2:    t = '{dr: OFS_DEC,  dc: OFS_INC};
            4'd3:    t = '{dr: OFS_SAME, dc: OFS_DEC};
            4'd4:    t = '{dr: OFS_SAME, dc: OFS_SAME};
            4'd5:    t = '{dr: OFS_SAME, dc: OFS_INC};
            4'd6:    t = '{dr: OFS_INC,  dc: OFS_DEC};
            4'd7:    t = '{dr: OFS_INC,  dc: OFS_SAME};
            4'd8:    t = '{dr: OFS_INC,  dc: OFS_INC};
            default: t = '{dr: OFS_SAME, dc: OFS_SAME};
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/core/neighbour_mean_smoothing.sv =====
// ----------------------------------------------------------------------------
// neighbour_mean_smoothing
// Stored-matrix 3x3 neighbour mean, centre excluded, 8 fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one beat per write or query; s_tuser is the mode
//   (0 write element, 1 query). A write stores element_value at
//   row_index, column_index and returns no beat.
//   A query returns one m_ beat: mean_value (sum * 256 / count, truncated
//   toward zero) and neighbour_count.
//   A query of a cell inside the matrix walks the window through the
//   single RAM read port, then runs the bit-serial divider (27 quotient
//   bits, one per cycle, then the done cycle), and then loads the output
//   register. A query outside the matrix goes straight to the output
//   register; a cell with no neighbours skips the divider.
//   s_tready is low while a query is being worked on.
//   The result sits in an output register; a new item is accepted while it
//   waits. If the receiver stalls, the next query holds in its final step
//   until the output register frees up.
//   Reset (synchronous, aresetn low) sets row_count and column_count to 64
//   and empties the output; the matrix store is not cleared and must be
//   written before it is read.
//   cfg_ writes take effect at once and must be made only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "neighbour_mean_smoothing_defines.svh"

module neighbour_mean_smoothing (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [nms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nms_pkg::DIM_W-1:0]     cfg_wr_data,
    // input beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // row_index, column_index, element_value
    input  logic [0:0]                    s_tuser,   // mode
    // result beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata    // mean_value, neighbour_count
);

    import nms_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [DIM_W-1:0]  row_count_reg, row_count_next;
    logic [DIM_W-1:0]  column_count_reg, column_count_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [QUO_W-1:0]  res_mean_reg, res_mean_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic [DATA_W-1:0] in_value;
    logic              in_mode;
    logic              accept;

    logic [DIM_W-1:0]  rows, cols;
    logic              in_matrix;

    tap_t              tap;
    logic              row_ok, col_ok, tap_ok;
    logic [ROW_W-1:0]  nb_row;
    logic [COL_W-1:0]  nb_col;

    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;

    logic              div_start, div_done, div_neg;
    logic [SUM_W-1:0]  sum_mag;
    logic [QUO_W-1:0]  div_quotient;
    logic              out_free;

    assign in_row   = s_tdata[ROW_W-1:0];
    assign in_col   = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_value = s_tdata[ROW_W+COL_W+DATA_W-1:ROW_W+COL_W];
    assign in_mode  = s_tuser[0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Clamp dimensions to 1..max
    always_comb begin
        rows = row_count_reg;
        if (rows == '0) begin
            rows = DIM_W'(1);
        end else if (rows > DIM_W'(MAX_ROWS)) begin
            rows = DIM_W'(MAX_ROWS);
        end
        cols = column_count_reg;
        if (cols == '0) begin
            cols = DIM_W'(1);
        end else if (cols > DIM_W'(MAX_COLUMNS)) begin
            cols = DIM_W'(MAX_COLUMNS);
        end
    end

    assign in_matrix = ({1'b0, in_row} < rows) && ({1'b0, in_col} < cols);

    // Neighbour address and range check for the current window tap
    always_comb begin
        tap    = tap_offset(tap_reg);
        row_ok = 1'b1;
        col_ok = 1'b1;
        nb_row = row_reg;
        nb_col = col_reg;
        case (tap.dr)
            OFS_DEC: begin
                row_ok = (row_reg != '0);
                nb_row = row_reg - 1'b1;
            end
            OFS_INC: begin
                row_ok = (({1'b0, row_reg} + 1'b1) < rows);
                nb_row = row_reg + 1'b1;
            end
            default: begin
                row_ok = 1'b1;
            end
        endcase
        case (tap.dc)
            OFS_DEC: begin
                col_ok = (col_reg != '0);
                nb_col = col_reg - 1'b1;
            end
            OFS_INC: begin
                col_ok = (({1'b0, col_reg} + 1'b1) < cols);
                nb_col = col_reg + 1'b1;
            end
            default: begin
                col_ok = 1'b1;
            end
        endcase
        tap_ok = (state_reg == ST_SCAN) && (tap_reg < TAP_W'(TAP_LAST))
                 && (tap_reg != TAP_W'(TAP_MID)) && row_ok && col_ok;
    end

    assign ram_we = accept && !in_mode;

    nms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr ({in_row, in_col}),
        .wr_data (in_value),
        .rd_addr ({nb_row, nb_col}),
        .rd_data (ram_rdata)
    );

    // Accumulate the word read on the previous cycle
    assign sum_next = rd_pend_reg
        ? sum_reg + {{(SUM_W-DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata}
        : sum_reg;

    assign div_neg = sum_next[SUM_W-1];
    assign sum_mag = div_neg ? (~sum_next + 1'b1) : sum_next;

    nms_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (div_start),
        .dividend_mag ({sum_mag, {FRAC_W{1'b0}}}),
        .negate       (div_neg),
        .divisor      (count_reg),
        .done         (div_done),
        .quotient     (div_quotient)
    );

    always_comb begin
        state_next        = state_reg;
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        tap_next          = tap_reg;
        count_next        = count_reg;
        rd_pend_next      = tap_ok;
        res_mean_next     = res_mean_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        div_start         = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROW_COUNT:    row_count_next    = cfg_wr_data;
                REG_COLUMN_COUNT: column_count_next = cfg_wr_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept && in_mode) begin
                    row_next   = in_row;
                    col_next   = in_col;
                    tap_next   = '0;
                    count_next = '0;
                    res_mean_next = '0;
                    state_next = in_matrix ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN: begin
                if (tap_ok) begin
                    count_next = count_reg + 1'b1;
                end
                tap_next = tap_reg + 1'b1;
                if (tap_reg == TAP_W'(TAP_LAST)) begin
                    // last read has landed in sum_next
                    if (count_reg == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_mean_next = div_quotient;
                    state_next    = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(32-QUO_W-CNT_W){1'b0}}, count_reg, res_mean_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            row_count_reg    <= DIM_W'(64);
            column_count_reg <= DIM_W'(64);
            rd_pend_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            rd_pend_reg      <= rd_pend_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        row_reg      <= row_next;
        col_reg      <= col_next;
        tap_reg      <= tap_next;
        count_reg    <= count_next;
        // clear the sum when a query starts
        sum_reg      <= (state_reg == ST_IDLE) ? '0 : sum_next;
        res_mean_reg <= res_mean_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `NMS_ASSERT_IMP(a_done_in_div, aclk, aresetn, div_done, state_reg == ST_DIV)
    `NMS_ASSERT_IMP(a_count_max, aclk, aresetn, state_reg == ST_SCAN, count_reg <= CNT_W'(8))
    `NMS_ASSERT_NXT(a_query_busy, aclk, aresetn, accept && in_mode, state_reg != ST_IDLE)
    `NMS_ASSERT_NXT(a_fin_loads, aclk, aresetn, (state_reg == ST_FIN) && out_free,
                    m_tvalid_reg && (state_reg == ST_IDLE))

endmodule

// ===== rtl/core/nms_ram.sv =====
// ----------------------------------------------------------------------------
// nms_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/nms_div.sv =====
// ----------------------------------------------------------------------------
// nms_div
// Bit-serial restoring divider: signed sum * 256 over a count of 1 to 8.
// ----------------------------------------------------------------------------
module nms_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [nms_pkg::DVD_W-1:0]  dividend_mag,
    input  logic                       negate,
    input  logic [nms_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [nms_pkg::QUO_W-1:0]  quotient
);

    import nms_pkg::*;

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [STEP_W-1:0]   step_reg,  step_next;
    logic [DVD_W-1:0]    quo_reg,   quo_next;
    logic [REM_W-1:0]    rem_reg,   rem_next;
    logic [CNT_W-1:0]    dsr_reg,   dsr_next;
    logic                neg_reg,   neg_next;

    logic [REM_W:0]      trial;
    logic                fits;
    logic [REM_W:0]      diff;
    logic [QUO_W-1:0]    mag;

    always_comb begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        fits  = trial >= dsr_reg;
        diff  = trial - dsr_reg;

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;

        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend_mag;
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = negate;
        end else if (busy_reg) begin
            // shift one quotient bit in per cycle
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
    end

    // magnitude never exceeds 2^23, so the low bits hold it exactly
    assign mag      = quo_reg[QUO_W-1:0];
    assign quotient = neg_reg ? (~mag + 1'b1) : mag;
    assign done     = done_reg;

endmodule

// ===== verif/tb_neighbour_mean_smoothing.sv =====
// ----------------------------------------------------------------------------
// tb_neighbour_mean_smoothing
// Writes matrix cells and queries 3x3 neighbour means over several matrix
// sizes. Each query result is checked against a local model of the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_neighbour_mean_smoothing;

    import nms_pkg::*;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam int   QUIET_LIMIT = 4000;
    localparam int   SEG_ITEMS   = 130;

    typedef struct packed {
        logic              mode;
        logic [5:0]        row;
        logic [5:0]        col;
        logic signed [15:0] value;
    } cell_item_t;

    typedef struct packed {
        logic signed [23:0] mean;
        logic [3:0]         count;
    } smooth_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;

    neighbour_mean_smoothing i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    cell_item_t     item_queue[$];
    smooth_result_t mean_queue[$];

    // model of the block, updated on accepted beats
    logic signed [15:0] shadow_store [0:MAX_ROWS*MAX_COLUMNS-1];
    logic [DIM_W-1:0]   row_setting = 7'd64;
    logic [DIM_W-1:0]   col_setting = 7'd64;

    // stimulus side bookkeeping
    bit gen_written [0:MAX_ROWS*MAX_COLUMNS-1];
    int gen_rows = 64;
    int gen_cols = 64;
    int item_count = 0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    cell_item_t     drv_item;
    smooth_result_t due;
    smooth_result_t got;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int dim_in_use(input logic [DIM_W-1:0] setting, input int limit);
        int d;
        d = setting;
        if (d < 1) d = 1;
        if (d > limit) d = limit;
        return d;
    endfunction

    function automatic smooth_result_t smoothed_mean(input int row, input int col);
        int rows, cols, sum, cnt, r, c, mean;
        smooth_result_t res;
        rows = dim_in_use(row_setting, MAX_ROWS);
        cols = dim_in_use(col_setting, MAX_COLUMNS);
        sum = 0;
        cnt = 0;
        mean = 0;
        if (row < rows && col < cols) begin
            for (r = row - 1; r <= row + 1; r++) begin
                for (c = col - 1; c <= col + 1; c++) begin
                    if (!(r == row && c == col) && r >= 0 && r < rows && c >= 0 && c < cols) begin
                        sum += shadow_store[r * MAX_COLUMNS + c];
                        cnt++;
                    end
                end
            end
            if (cnt > 0) mean = (sum * 256) / cnt;
        end
        res.mean  = mean[23:0];
        res.count = cnt[3:0];
        return res;
    endfunction

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_write(input int r, input int c, input logic [15:0] v);
        item_queue.push_back('{mode: MODE_WRITE, row: r[5:0], col: c[5:0], value: v});
        gen_written[r * MAX_COLUMNS + c] = 1'b1;
        item_count++;
    endtask

    // fill any unwritten cell of the window first, then query
    task automatic query_cell(input int r, input int c);
        int rr, cc;
        if (r < gen_rows && c < gen_cols) begin
            for (rr = r - 1; rr <= r + 1; rr++) begin
                for (cc = c - 1; cc <= c + 1; cc++) begin
                    if (rr >= 0 && rr < gen_rows && cc >= 0 && cc < gen_cols &&
                        !gen_written[rr * MAX_COLUMNS + cc])
                        push_write(rr, cc, rand_value());
                end
            end
        end
        item_queue.push_back('{mode: MODE_QUERY, row: r[5:0], col: c[5:0],
                               value: 16'($urandom)});
        item_count++;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (item_queue.size() != 0 || s_tvalid || mean_queue.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
        wait_idle();
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COLUMN_COUNT, cols);
        gen_rows = dim_in_use(rows, MAX_ROWS);
        gen_cols = dim_in_use(cols, MAX_COLUMNS);
    endtask

    // stimulus
    initial begin
        logic [DIM_W-1:0] seg_rows [0:14];
        logic [DIM_W-1:0] seg_cols [0:14];
        int seg, target, r, c, rr;
        seg_rows = '{7'd8, 7'd1, 7'd64, 7'd0, 7'd3, 7'd64, 7'd2, 7'd127,
                     7'd7, 7'd4, 7'd65, 7'd16, 7'd1, 7'd64, 7'd5};
        seg_cols = '{7'd8, 7'd64, 7'd64, 7'd127, 7'd5, 7'd2, 7'd64, 7'd0,
                     7'd3, 7'd4, 7'd9, 7'd16, 7'd1, 7'd1, 7'd6};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // corners at full size (most positive mean), then an all-negative window for the most negative mean
        push_write(0, 0, 16'h7fff);
        push_write(0, 1, 16'h8000);
        push_write(1, 0, 16'h7fff);
        push_write(1, 1, 16'h8000);
        query_cell(0, 0);
        push_write(62, 62, 16'h7fff);
        push_write(62, 63, 16'h7fff);
        push_write(63, 62, 16'h7fff);
        push_write(63, 63, 16'h5555);
        query_cell(63, 63);
        for (rr = 0; rr < 9; rr++) push_write(10 + rr / 3, 20 + rr % 3, 16'h8000);
        query_cell(11, 21);
        // 1x1 matrix: no neighbours, and a cell outside the matrix
        set_dims(7'd0, 7'd1);
        query_cell(0, 0);
        query_cell(5, 5);
        // oversize rows, one column
        set_dims(7'd127, 7'd1);
        query_cell(63, 0);

        for (seg = 0; seg < 15; seg++) begin
            set_dims(seg_rows[seg], seg_cols[seg]);
            case (seg / 5)
                0:       begin tx_idle_pct = 6;  rx_idle_pct = 45; end
                1:       begin tx_idle_pct = 45; rx_idle_pct = 6;  end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            // long receiver stall while queries keep coming
            if (seg == 0) rx_hold_req = 400;
            target = item_count + SEG_ITEMS;
            while (item_count < target) begin
                if ($urandom_range(0, 9) < 4) begin
                    if ($urandom_range(0, 9) < 7) begin
                        r = $urandom_range(0, gen_rows - 1);
                        c = $urandom_range(0, gen_cols - 1);
                    end else begin
                        r = $urandom_range(0, 63);
                        c = $urandom_range(0, 63);
                    end
                    push_write(r, c, rand_value());
                end else begin
                    if ($urandom_range(0, 9) != 0) begin
                        r = $urandom_range(0, gen_rows - 1);
                        c = $urandom_range(0, gen_cols - 1);
                    end else begin
                        r = $urandom_range(0, 63);
                        c = $urandom_range(0, 63);
                    end
                    query_cell(r, c);
                end
                @(posedge aclk);
            end
        end

        do @(negedge aclk);
        while (item_queue.size() != 0 || s_tvalid || mean_queue.size() != 0);
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (item_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                drv_item = item_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, drv_item.value, drv_item.col, drv_item.row};
                s_tuser  <= drv_item.mode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_hold_req > 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // monitor: track config and store, predict queries, check results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ROW_COUNT:    row_setting = cfg_wr_data;
                    REG_COLUMN_COUNT: col_setting = cfg_wr_data;
                    default:          ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == MODE_WRITE)
                    shadow_store[{s_tdata[5:0], s_tdata[11:6]}] = s_tdata[27:12];
                else
                    mean_queue.push_back(smoothed_mean(s_tdata[5:0], s_tdata[11:6]));
            end
            if (m_tvalid && m_tready) begin
                got.mean  = m_tdata[23:0];
                got.count = m_tdata[27:24];
                if (mean_queue.size() == 0) begin
                    $display("%0t: unexpected result beat, mean %0d count %0d",
                             $time, got.mean, got.count);
                    mismatches++;
                end else begin
                    due = mean_queue.pop_front();
                    if (got.mean !== due.mean) begin
                        $display("%0t: mean_value expected %0d actual %0d",
                                 $time, due.mean, got.mean);
                        mismatches++;
                    end
                    if (got.count !== due.count) begin
                        $display("%0t: neighbour_count expected %0d actual %0d",
                                 $time, due.count, got.count);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/nms_pkg.sv
rtl/core/nms_ram.sv
rtl/core/nms_div.sv
rtl/core/neighbour_mean_smoothing.sv
verif/tb_neighbour_mean_smoothing.sv
